// ===== rtl/core/delta_list_timer_queue_unit_assert.svh =====
// assertion macros for the delta-list timer queue
// needs a clock and an active-low reset passed in by the user
`ifndef DELTA_LIST_TIMER_QUEUE_UNIT_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DLTQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue check failed");

// next-cycle implication, disabled during reset
`define DLTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue check failed");

`endif

// ===== rtl/core/dltq_pkg.sv =====
// shared types and constants for the delta-list timer queue
// no dependencies
package dltq_pkg;

    // default sizes
    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    // fixed field widths
    localparam int SEQ_W   = 16;
    localparam int DELTA_W = 8;

    // register reset value
    localparam logic [DELTA_W-1:0] TIMEOUT_RST = 8'd5;

    // item kinds
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_START  = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DEC_HEAD,
        OP_SHIFT_ALL,
        OP_CANCEL,
        OP_APPEND
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [DELTA_W-1:0] new_delta;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/dltq_if.sv =====
// valid/ready channel interfaces for the delta-list timer queue
// depends on dltq_pkg
interface dltq_req_if;
    import dltq_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic [SEQ_W-1:0] seq_id;

    modport source (output valid, output kind, output seq_id, input ready);
    modport sink (input valid, input kind, input seq_id, output ready);
endinterface

interface dltq_rsp_if #(
    parameter int CNT_W = 5
);
    import dltq_pkg::*;

    logic             valid;
    logic             ready;
    logic             expired_valid;
    logic [SEQ_W-1:0] expired_id;
    logic [1:0]       status;
    logic [CNT_W-1:0] entries;

    modport source (output valid, output expired_valid, output expired_id,
                    output status, output entries, input ready);
    modport sink (input valid, input expired_valid, input expired_id,
                  input status, input entries, output ready);
endinterface

// ===== rtl/core/dltq_cell.sv =====
// one timer slot of the delta-list chain: id, delta and match flag
// depends on dltq_pkg; takes its right neighbor's contents on a shift
module dltq_cell #(
    parameter int IDX     = 0,
    parameter int ID_BITS = dltq_pkg::ID_BITS_DEF,
    parameter int CNT_W   = 5
) (
    input  logic                         clk,
    input  dltq_pkg::cell_ctrl_t         ctrl,
    input  logic [ID_BITS-1:0]           key,
    input  logic [CNT_W-1:0]             count,
    input  logic [ID_BITS-1:0]           nb_id,
    input  logic [dltq_pkg::DELTA_W-1:0] nb_delta,
    input  logic                         found_in,
    output logic [ID_BITS-1:0]           id,
    output logic [dltq_pkg::DELTA_W-1:0] delta,
    output logic                         found_out,
    output logic [dltq_pkg::DELTA_W-1:0] drop_delta
);
    import dltq_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_IX = CNT_W'(IDX + 1);
    localparam bit               IS_HEAD = (IDX == 0);

    logic [ID_BITS-1:0] id_reg, id_next;
    logic [DELTA_W-1:0] delta_reg, delta_next;
    logic               match_reg, match_next;
    logic               occupied, first_hit, is_last;
    logic [DELTA_W:0]   merged;

    assign occupied = (MY_IDX < count);
    assign is_last  = (count == NEXT_IX);

    // match against the held key, registered for the apply cycle
    assign match_next = occupied && (id_reg == key);

    // first match from the head is the one that goes
    assign first_hit  = match_reg && !found_in;
    assign found_out  = found_in || match_reg;
    assign drop_delta = (first_hit && is_last) ? delta_reg : '0;

    // merged delta for the entry that follows a cancelled one
    assign merged = {1'b0, nb_delta} + {1'b0, delta_reg};

    // next contents per broadcast operation
    always_comb
    begin
        id_next    = id_reg;
        delta_next = delta_reg;
        unique case (ctrl.op)
            OP_NONE:
            begin
            end
            OP_DEC_HEAD:
            begin
                if (IS_HEAD && (delta_reg != '0))
                begin
                    delta_next = delta_reg - DELTA_W'(1);
                end
            end
            OP_SHIFT_ALL:
            begin
                id_next    = nb_id;
                delta_next = nb_delta;
            end
            OP_CANCEL:
            begin
                if (found_out)
                begin
                    id_next    = nb_id;
                    delta_next = nb_delta;
                    if (first_hit)
                    begin
                        delta_next = merged[DELTA_W] ? '1 : merged[DELTA_W-1:0];
                    end
                end
            end
            OP_APPEND:
            begin
                if (count == MY_IDX)
                begin
                    id_next    = key;
                    delta_next = ctrl.new_delta;
                end
            end
            default:
            begin
            end
        endcase
    end

    // slot storage, no reset
    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        delta_reg <= delta_next;
        match_reg <= match_next;
    end

    assign id    = id_reg;
    assign delta = delta_reg;

endmodule

// ===== rtl/core/delta_list_timer_queue_unit.sv =====
// Delta-list timer queue: a row of slots, head at slot 0, all sharing one timeout.
// Sequence: an item is taken in idle, ids are compared against the held key in the
// match state, and the change is applied with the result in the apply state, which
// waits until the result register is free; the match is registered in every slot.
// A new item is taken only back in idle, once the previous one has been applied.
// Reset: queue empty, timeout back to 5, no result pending; slot contents untouched.
`include "delta_list_timer_queue_unit_assert.svh"

module delta_list_timer_queue_unit #(
    parameter int DEPTH   = dltq_pkg::DEPTH_DEF,
    parameter int ID_BITS = dltq_pkg::ID_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [dltq_pkg::DELTA_W-1:0] cfg_wdata,
    dltq_req_if.sink                     req,
    dltq_rsp_if.source                   rsp
);
    import dltq_pkg::*;

    localparam int               CNT_W    = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         kind_reg;
    logic [ID_BITS-1:0] key_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DELTA_W-1:0] sum_reg, sum_next;
    logic [DELTA_W-1:0] timeout_reg;
    logic               out_valid_reg;
    logic               out_exp_reg, out_exp_next;
    logic [SEQ_W-1:0]   out_id_reg, out_id_next;
    logic [1:0]         out_status_reg, out_status_next;

    cell_ctrl_t         ctrl;
    logic               fire;
    logic               expire;
    logic [DELTA_W-1:0] drop_sum;
    logic [DELTA_W-1:0] append_delta;

    logic [ID_BITS-1:0] cell_id    [DEPTH];
    logic [DELTA_W-1:0] cell_delta [DEPTH];
    logic [DELTA_W-1:0] cell_drop  [DEPTH];
    logic [DEPTH:0]     found_chain;

    assign found_chain[0] = 1'b0;

    // the slot chain, each slot fed by its right neighbor
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [ID_BITS-1:0] nb_id;
        logic [DELTA_W-1:0] nb_delta;

        if (g == DEPTH - 1)
        begin : g_tail
            assign nb_id    = '0;
            assign nb_delta = '0;
        end
        else
        begin : g_mid
            assign nb_id    = cell_id[g+1];
            assign nb_delta = cell_delta[g+1];
        end

        dltq_cell #(
            .IDX     (g),
            .ID_BITS (ID_BITS),
            .CNT_W   (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .key        (key_reg),
            .count      (count_reg),
            .nb_id      (nb_id),
            .nb_delta   (nb_delta),
            .found_in   (found_chain[g]),
            .id         (cell_id[g]),
            .delta      (cell_delta[g]),
            .found_out  (found_chain[g+1]),
            .drop_delta (cell_drop[g])
        );
    end

    // delta of a cancelled tail slot, zero from all others
    always_comb
    begin
        drop_sum = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            drop_sum = drop_sum | cell_drop[i];
        end
    end

    // update fires once the result register is free
    assign fire         = (state_reg == S_APPLY) && (!out_valid_reg || rsp.ready);
    assign expire       = (count_reg != '0) && (cell_delta[0] <= DELTA_W'(1));
    assign append_delta = (timeout_reg > sum_reg) ? (timeout_reg - sum_reg) : '0;

    // operation decode and result
    always_comb
    begin
        ctrl.op         = OP_NONE;
        ctrl.new_delta  = append_delta;
        count_next      = count_reg;
        sum_next        = sum_reg;
        out_exp_next    = 1'b0;
        out_id_next     = '0;
        out_status_next = ST_OK;
        unique case (kind_t'(kind_reg))
            KIND_TICK:
            begin
                if (count_reg != '0)
                begin
                    if (cell_delta[0] != '0)
                    begin
                        sum_next = sum_reg - DELTA_W'(1);
                    end
                    if (expire)
                    begin
                        ctrl.op      = OP_SHIFT_ALL;
                        count_next   = count_reg - CNT_W'(1);
                        out_exp_next = 1'b1;
                        out_id_next  = SEQ_W'(cell_id[0]);
                    end
                    else
                    begin
                        ctrl.op = OP_DEC_HEAD;
                    end
                end
            end
            KIND_START:
            begin
                if (count_reg == CNT_FULL)
                begin
                    out_status_next = ST_FULL;
                end
                else
                begin
                    ctrl.op    = OP_APPEND;
                    count_next = count_reg + CNT_W'(1);
                    sum_next   = sum_reg + append_delta;
                end
            end
            KIND_CANCEL:
            begin
                if (found_chain[DEPTH])
                begin
                    ctrl.op    = OP_CANCEL;
                    count_next = count_reg - CNT_W'(1);
                    sum_next   = sum_reg - drop_sum;
                end
                else
                begin
                    out_status_next = ST_NOTFOUND;
                end
            end
            KIND_NOP:
            begin
            end
            default:
            begin
            end
        endcase
        if (!fire)
        begin
            ctrl.op = OP_NONE;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, queue bookkeeping and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            timeout_reg   <= TIMEOUT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (fire)
            begin
                count_reg     <= count_next;
                sum_reg       <= sum_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and result payload, no reset
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            kind_reg <= req.kind;
            key_reg  <= ID_BITS'(req.seq_id);
        end
        if (fire)
        begin
            out_exp_reg    <= out_exp_next;
            out_id_reg     <= out_id_next;
            out_status_reg <= out_status_next;
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.expired_valid = out_exp_reg;
    assign rsp.expired_id    = out_id_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.entries       = count_reg;

    // checks on queue bookkeeping
    `DLTQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL)
    `DLTQ_ASSERT_NOW(a_empty_sum, clk, rst_n, count_reg == '0, sum_reg == '0)
    `DLTQ_ASSERT_NEXT(a_expire_pops, clk, rst_n, fire && out_exp_next,
        count_reg == $past(count_reg) - CNT_W'(1))
    `DLTQ_ASSERT_NOW(a_expire_ok, clk, rst_n, rsp.valid && rsp.expired_valid,
        rsp.status == ST_OK)

endmodule
